// ===== hdl/dq_pkg.sv =====
// Package for the double-ended queue: sizes, op and status codes, word types.
// No dependencies; used by every module under hdl.
package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int DATA_W     = 32;

  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_IDX_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam int RESQ_DEPTH = 2;
  localparam int RQ_IDX_W   = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RQ_CNT_W   = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
    logic                     last;
  } res_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

// ===== hdl/dq_front.sv =====
// Front end: accepts input words, drops unknown op codes, queues commands.
// Depends on dq_pkg.
module dq_front import dq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [2:0]               op_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     cmd_valid_o,
  output cmd_t                     cmd_o,
  input  logic                     cmd_pop_i
);

  cmd_t                slot_q [CMDQ_DEPTH];
  logic [CQ_IDX_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                known_op, wr_en, rd_en;

  assign full        = (cnt_q == CQ_CNT_W'(CMDQ_DEPTH));
  assign known_op    = (op_i <= 3'(OP_DUMP));
  assign wr_en       = push && !full && known_op;
  assign rd_en       = cmd_pop_i && (cnt_q != '0);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == CQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + CQ_IDX_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == CQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + CQ_IDX_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CQ_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= '{op: op_e'(op_i), value: value_i};
    end
  end

endmodule

// ===== hdl/dq_back.sv =====
// Back end: ring buffer storage, indices and count; runs one command at a time.
// Depends on dq_pkg.
module dq_back import dq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_wr_o,
  output res_t res_o,
  input  logic res_full_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d, back_q, back_d, ptr_q, ptr_d, remain_q, remain_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             we, re, is_full, is_empty;
  logic [IDX_W-1:0] waddr, raddr;

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    back_d    = back_q;
    ptr_d     = ptr_q;
    remain_d  = remain_q;
    count_d   = count_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = back_q;
    raddr     = front_q;
    cmd_pop_o = 1'b0;
    res_wr_o  = 1'b0;
    res_o     = '{value: '0, status: ST_OK, last: 1'b1};
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (!res_full_i) begin
                cmd_pop_o = 1'b1;
                res_wr_o  = 1'b1;
                if (is_full) begin
                  res_o.status = ST_FULL;
                end else begin
                  we      = 1'b1;
                  count_d = count_q + CNT_W'(1);
                  if (cmd_i.op == OP_PUSH_FRONT) begin
                    waddr   = idx_prev(front_q);
                    front_d = idx_prev(front_q);
                  end else begin
                    back_d = idx_next(back_q);
                  end
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                if (!res_full_i) begin
                  cmd_pop_o    = 1'b1;
                  res_wr_o     = 1'b1;
                  res_o.status = ST_EMPTY;
                end
              end else begin
                cmd_pop_o = 1'b1;
                re        = 1'b1;
                count_d   = count_q - CNT_W'(1);
                state_d   = S_POP;
                if (cmd_i.op == OP_POP_FRONT) begin
                  front_d = idx_next(front_q);
                end else begin
                  raddr  = idx_prev(back_q);
                  back_d = idx_prev(back_q);
                end
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                if (!res_full_i) begin
                  cmd_pop_o    = 1'b1;
                  res_wr_o     = 1'b1;
                  res_o.status = ST_EMPTY;
                end
              end else begin
                cmd_pop_o = 1'b1;
                re        = 1'b1;
                ptr_d     = idx_next(front_q);
                remain_d  = IDX_W'(count_q - CNT_W'(1));
                state_d   = S_DUMP;
              end
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      S_POP: begin
        if (!res_full_i) begin
          res_wr_o    = 1'b1;
          res_o.value = rdata_q;
          state_d     = S_IDLE;
        end
      end
      S_DUMP: begin
        if (!res_full_i) begin
          res_wr_o    = 1'b1;
          res_o.value = rdata_q;
          res_o.last  = (remain_q == '0);
          if (remain_q == '0) begin
            state_d = S_IDLE;
          end else begin
            re       = 1'b1;
            raddr    = ptr_q;
            ptr_d    = idx_next(ptr_q);
            remain_d = remain_q - IDX_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      back_q   <= '0;
      count_q  <= '0;
      ptr_q    <= '0;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      remain_q <= remain_d;
    end
  end

  // single-port storage, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= cmd_i.value;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

endmodule

// ===== hdl/dq_res_fifo.sv =====
// Result queue between the back end and the output ports.
// Depends on dq_pkg.
module dq_res_fifo import dq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  res_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output res_t rd_data_o,
  output logic empty_o
);

  res_t                slot_q [RESQ_DEPTH];
  logic [RQ_IDX_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [RQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                wr, rd;

  assign full_o    = (cnt_q == RQ_CNT_W'(RESQ_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign wr        = wr_en_i && !full_o;
  assign rd        = rd_en_i && !empty_o;
  assign rd_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == RQ_IDX_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_q + RQ_IDX_W'(1);
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == RQ_IDX_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_q + RQ_IDX_W'(1);
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + RQ_CNT_W'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - RQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words, top level.
// Depends on dq_pkg, dq_front, dq_back and dq_res_fifo.
//
// Input side: a word (op_i, value_i) is taken when push is high and full is low.
// Op codes: push front, push back, pop front, pop back, dump. Unknown codes are
// taken and dropped without a result. Output side: while empty is low the
// oldest result (value_out_o, status_o, last_o) is on the ports; it is taken
// when pop is high. last_o marks the final result of each input word.
// A push or an empty/full answer goes to the result queue straight from the
// idle back end; a pop or a dump first reads the storage into a register, and
// a dump then gives one word per cycle while the result queue has room. A push
// can follow every cycle while the result queue has room; a pop holds the back
// end until its word is out, set by the single read port of the storage with
// its registered read data. A two-entry command queue and a two-entry result
// queue decouple the sides: when pop stays low the back end stops once the
// result queue fills, then the command queue fills and full goes high.
// Reset (rst_ni low, asynchronous) empties the store and both queues; the
// storage words themselves are not cleared.
module double_ended_queue import dq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [2:0]               op_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [DATA_W-1:0] value_out_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  logic cmd_valid, cmd_pop, res_wr, res_full;
  cmd_t cmd;
  res_t res, res_head;

  dq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .op_i       (op_i),
    .value_i    (value_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  dq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_wr_o   (res_wr),
    .res_o      (res),
    .res_full_i (res_full)
  );

  dq_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (res_wr),
    .wr_data_i(res),
    .full_o   (res_full),
    .rd_en_i  (pop),
    .rd_data_o(res_head),
    .empty_o  (empty)
  );

  assign value_out_o = res_head.value;
  assign status_o    = res_head.status;
  assign last_o      = res_head.last;

`ifndef NO_ASSERTIONS
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr |-> !res_full)
    else $error("result written into a full result queue");

  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty command queue");

  a_status_zero_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_wr && res.status != ST_OK) |-> (res.last && res.value == '0))
    else $error("empty or full answer not a single zero word");
`endif

endmodule
